>>> hdl/alid_pkg.sv
// Package for the bounded array list block: sizes, status and action codes,
// and the structs passed between the sequencer and the entry RAM.
// No dependencies.
package alid_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int FIDX_W = 4;
    localparam int LEN_W  = 5;
    localparam int ACT_W  = 2;
    localparam int ST_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADPOS  = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [FIDX_W-1:0] found_index;
        logic [LEN_W-1:0]  length;
    } result_t;

endpackage

>>> hdl/array_list_insert_delete_find.sv
// Top level of the bounded array list: stream ports, output register and
// checks. Instantiates alid_seq and alid_ram; depends on alid_pkg.
//
// Usage: each request transfer on the s_ channel carries an action in
// s_tuser (find, insert at a 1-based position, delete at a position) and the
// position and value in s_tdata. Exactly one result transfer leaves on the
// m_ channel for each request: a status code in m_tuser and the found index
// and the list length after the request in m_tdata.
// Requests are handled one at a time. A find reads the store one entry per
// cycle; insert and delete move one entry per cycle through the single RAM
// read and write port; rejected and unused requests skip this work. From the
// sequencer each result passes to the output register.
// s_tready is high only while the sequencer is idle. The output register
// lets the next request enter while a finished result still waits; if the
// receiver holds m_tready low, the following result waits in the sequencer
// and no further request is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; the stored entries are not cleared, no clearing pass is needed.
module array_list_insert_delete_find (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] position, [36:5] value, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] found_index, [8:4] length, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import alid_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rd_data;
    logic              res_valid;
    logic              res_take;
    result_t           res;
    logic              m_tvalid_reg;
    result_t           out_reg;

    alid_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_action   (action_t'(s_tuser)),
        .req_position (s_tdata[POS_W-1:0]),
        .req_value    (s_tdata[POS_W+DATA_W-1:POS_W]),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    alid_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign res_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.length, out_reg.found_index};

    // The list never reports more entries than the store holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:4] <= LEN_W'(DEPTH)))
        else $error("reported length exceeds the store depth");

    // Only a successful find carries a nonzero index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[3:0] == '0))
        else $error("nonzero index with a failing status");

    // A found index always lies inside the list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] != '0) |-> (LEN_W'(m_tdata[3:0]) < m_tdata[8:4]))
        else $error("found index beyond the list length");

    // Requests are handled one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

endmodule

>>> hdl/alid_ram.sv
// Entry store of the list: one write port and one read port, with registered
// read data. Depends on alid_pkg.
module alid_ram (
    input  logic                           aclk,
    input  alid_pkg::mem_req_t             req,
    output logic [alid_pkg::DATA_W-1:0]    rd_data
);
    import alid_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

>>> hdl/alid_seq.sv
// Request sequencer: checks each request, scans the store for find, and
// moves entries one per cycle for insert and delete. Depends on alid_pkg.
module alid_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  alid_pkg::action_t             req_action,
    input  logic [alid_pkg::POS_W-1:0]    req_position,
    input  logic [alid_pkg::DATA_W-1:0]   req_value,
    output alid_pkg::mem_req_t            mem_req,
    input  logic [alid_pkg::DATA_W-1:0]   mem_rd_data,
    output logic                          res_valid,
    input  logic                          res_take,
    output alid_pkg::result_t             res
);
    import alid_pkg::*;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIND  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0] ins_addr_reg, ins_addr_next;
    logic              up_reg, up_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_dst_reg, pend_dst_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    result_t           res_reg, res_next;

    logic [CMP_W-1:0]  pos_x, cnt_x;

    assign pos_x     = CMP_W'(req_position);
    assign cnt_x     = CMP_W'(count_reg);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        val_next        = val_reg;
        ins_addr_next   = ins_addr_reg;
        up_next         = up_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_dst_next   = pend_dst_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_next        = res_reg;
        mem_req.wr_en   = pend_valid_reg;
        mem_req.wr_addr = pend_dst_reg;
        mem_req.wr_data = mem_rd_data;
        mem_req.rd_addr = src_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    val_next   = req_value;
                    res_next   = '{status: ST_OK, found_index: '0,
                                   length: LEN_W'(count_reg)};
                    state_next = S_DONE;
                    case (req_action)
                        ACT_FIND: begin
                            scan_next      = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = S_FIND;
                        end
                        ACT_INSERT: begin
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                                res_next.status = ST_BADPOS;
                            end else begin
                                // Move entries pos-1 .. count-1 up by one, top first.
                                up_next         = 1'b1;
                                rem_next        = CNT_W'(cnt_x - pos_x + 1'b1);
                                src_next        = ADDR_W'(count_reg - 1'b1);
                                ins_addr_next   = ADDR_W'(req_position - 1'b1);
                                pend_valid_next = 1'b0;
                                state_next      = S_SHIFT;
                            end
                        end
                        ACT_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                res_next.status = ST_BADPOS;
                            end else begin
                                // Move entries pos .. count-1 down by one, bottom first.
                                up_next         = 1'b0;
                                rem_next        = CNT_W'(cnt_x - pos_x);
                                src_next        = ADDR_W'(req_position);
                                pend_valid_next = 1'b0;
                                state_next      = S_SHIFT;
                            end
                        end
                        default: begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_FIND: begin
                mem_req.wr_en   = 1'b0;
                mem_req.rd_addr = scan_reg[ADDR_W-1:0];
                if (cmp_valid_reg && mem_rd_data == val_reg) begin
                    res_next   = '{status: ST_OK, found_index: FIDX_W'(cmp_idx_reg),
                                   length: LEN_W'(count_reg)};
                    state_next = S_DONE;
                end else if (scan_reg < count_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        res_next   = '{status: ST_MISSING, found_index: '0,
                                       length: LEN_W'(count_reg)};
                        state_next = S_DONE;
                    end
                end
            end

            S_SHIFT: begin
                // The pending move writes the word read last cycle.
                if (rem_reg != '0) begin
                    pend_valid_next = 1'b1;
                    pend_dst_next   = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next        = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    rem_next        = rem_reg - 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        // Write port is free: place the new value, or for a delete shorten the list.
                        if (up_reg) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = ins_addr_reg;
                            mem_req.wr_data = val_reg;
                            count_next      = count_reg + 1'b1;
                        end else begin
                            count_next      = count_reg - 1'b1;
                        end
                        res_next   = '{status: ST_OK, found_index: '0,
                                       length: LEN_W'(count_next)};
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE: begin
                mem_req.wr_en = 1'b0;
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                mem_req.wr_en = 1'b0;
                state_next    = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        ins_addr_reg <= ins_addr_next;
        up_reg       <= up_next;
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        pend_dst_reg <= pend_dst_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_reg      <= res_next;
    end

endmodule
